@@ design/fir_filter_dc_offset_clamp_unit_assert.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef FIR_FILTER_DC_OFFSET_CLAMP_UNIT_ASSERT_SVH
`define FIR_FILTER_DC_OFFSET_CLAMP_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define FDC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("fdc assertion failed");
`define FDC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("fdc assertion failed");
`else
`define FDC_ASSERT(lbl, clk, rstn, prop)
`define FDC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ design/fdc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fdc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 32;
    localparam int PROD_W   = SAMPLE_W + 1 + COEF_W;
    localparam int RES_W    = 32;
    localparam int OUT_W    = 16;

    localparam logic [RES_W-1:0] DC_OFFSET = 32'd32767;
    localparam logic [OUT_W-1:0] OUT_MAX   = 16'hFFFF;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    typedef struct packed {
        logic shift;
        logic coef_we;
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ design/fdc_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module fdc_cell #(
    parameter int ACC_W = 54
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire        fdc_pkg::t_cell_ctl     i_ctl,
    input  wire        [fdc_pkg::SAMPLE_W-1:0] i_sample_in,
    input  wire signed [fdc_pkg::COEF_W-1:0]   i_coef,
    input  wire signed [ACC_W-1:0]             i_sum_in,
    output logic       [fdc_pkg::SAMPLE_W-1:0] o_sample,
    output logic signed [ACC_W-1:0]            o_sum
);

    logic        [fdc_pkg::SAMPLE_W-1:0] r_sample;
    logic signed [fdc_pkg::COEF_W-1:0]   r_coef;
    logic signed [fdc_pkg::PROD_W-1:0]   r_prod;
    logic signed [fdc_pkg::PROD_W-1:0]   n_prod;
    logic signed [ACC_W-1:0]             r_sum;
    logic signed [ACC_W-1:0]             n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
            r_coef   <= '0;
        end else begin
            if (i_ctl.shift) begin
                r_sample <= i_sample_in;
            end
            if (i_ctl.coef_we) begin
                r_coef <= i_coef;
            end
        end
    end

    always_comb begin
        n_prod = $signed({1'b0, r_sample}) * r_coef;
        n_sum  = i_sum_in + ACC_W'(r_prod);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_sum  <= n_sum;
    end

    assign o_sample = r_sample;
    assign o_sum    = r_sum;

endmodule

`default_nettype wire

@@ design/fir_filter_dc_offset_clamp_unit.sv @@
// Channel  | Handshake                 | Words
// ---------+---------------------------+------------------------------------------
// input    | i_in_valid / o_in_ready   | i_req_type i_sample i_coef_index i_coef_value
// output   | o_out_valid / i_out_ready | o_filtered
// config   | i_cfg_we (no wait)        | i_cfg_wdata (dc_enable)
//
// A coefficient word is written into the cell that i_coef_index selects. A sample word
// shifts the tap row, then the per-cell products are registered, the partial sum
// ripples down the cell row, and finally the output register is loaded.
// Synchronous active-low reset clears taps, coefficients, dc_enable and control.
// A full output register that is not taken holds the finished sum in the row.
`timescale 1ns / 1ps
`default_nettype none
`include "fir_filter_dc_offset_clamp_unit_assert.svh"

module fir_filter_dc_offset_clamp_unit #(
    parameter int ORDER     = 22,
    parameter int FRAC_BITS = 15
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire                                i_cfg_wdata,
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire                                i_req_type,
    input  wire        [fdc_pkg::SAMPLE_W-1:0] i_sample,
    input  wire        [4:0]                   i_coef_index,
    input  wire signed [fdc_pkg::COEF_W-1:0]   i_coef_value,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic       [fdc_pkg::OUT_W-1:0]    o_filtered
);

    localparam int TAPS     = ORDER + 1;
    localparam int ACC_W    = fdc_pkg::PROD_W + $clog2(TAPS);
    localparam int WIDE_W   = ACC_W + fdc_pkg::RES_W;
    localparam int CNT_W    = $clog2(TAPS + 2);
    localparam logic [CNT_W-1:0] DONE_CNT = CNT_W'(TAPS + 1);

    logic                              r_dc_en;
    logic                              r_busy;
    logic [CNT_W-1:0]                  r_cnt;
    logic                              r_out_valid;
    logic [fdc_pkg::OUT_W-1:0]         r_filtered;
    logic [fdc_pkg::OUT_W-1:0]         n_filtered;

    logic                              w_in_acc;
    logic                              w_take_sample;
    logic                              w_take_coef;
    logic                              w_done;
    logic                              w_load;

    fdc_pkg::t_cell_ctl                w_ctl [TAPS];
    logic        [fdc_pkg::SAMPLE_W-1:0] w_samp [TAPS];
    logic signed [ACC_W-1:0]           w_sum  [TAPS];

    logic signed [WIDE_W-1:0]          w_wide;
    logic signed [WIDE_W-1:0]          w_shift;
    logic [fdc_pkg::RES_W-1:0]         w_y;

    assign o_in_ready    = !r_busy;
    assign w_in_acc      = i_in_valid && o_in_ready;
    assign w_take_sample = w_in_acc && (i_req_type == fdc_pkg::REQ_SAMPLE);
    assign w_take_coef   = w_in_acc && (i_req_type == fdc_pkg::REQ_COEF);
    assign w_done        = r_busy && (r_cnt == DONE_CNT);
    assign w_load        = w_done && (!r_out_valid || i_out_ready);

    for (genvar k = 0; k < TAPS; k++) begin : g_cell
        assign w_ctl[k].shift   = w_take_sample;
        assign w_ctl[k].coef_we = w_take_coef && (32'(i_coef_index) == k);

        if (k == 0) begin : g_head
            fdc_cell #(.ACC_W(ACC_W)) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_ctl[k]),
                .i_sample_in (i_sample),
                .i_coef      (i_coef_value),
                .i_sum_in    ('0),
                .o_sample    (w_samp[k]),
                .o_sum       (w_sum[k])
            );
        end else begin : g_body
            fdc_cell #(.ACC_W(ACC_W)) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_ctl[k]),
                .i_sample_in (w_samp[k-1]),
                .i_coef      (i_coef_value),
                .i_sum_in    (w_sum[k-1]),
                .o_sample    (w_samp[k]),
                .o_sum       (w_sum[k])
            );
        end
    end

    always_comb begin
        w_wide  = {{fdc_pkg::RES_W{w_sum[TAPS-1][ACC_W-1]}}, w_sum[TAPS-1]};
        w_shift = w_wide >>> FRAC_BITS;
        w_y     = w_shift[fdc_pkg::RES_W-1:0] + (r_dc_en ? fdc_pkg::DC_OFFSET : '0);
        if (w_y[fdc_pkg::RES_W-1]) begin
            n_filtered = '0;
        end else if (|w_y[fdc_pkg::RES_W-2:fdc_pkg::OUT_W]) begin
            n_filtered = fdc_pkg::OUT_MAX;
        end else begin
            n_filtered = w_y[fdc_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc_en     <= 1'b0;
            r_busy      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dc_en <= i_cfg_wdata;
            end
            if (w_take_sample) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (w_load) begin
                r_busy <= 1'b0;
            end else if (r_busy && !w_done) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_filtered <= n_filtered;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_filtered  = r_filtered;

    `FDC_ASSERT(a_sample_starts_run, i_clk, i_rst_n, w_take_sample |=> r_busy && r_cnt == '0)
    `FDC_ASSERT(a_coef_stays_idle, i_clk, i_rst_n, w_take_coef |=> !r_busy)
    `FDC_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= DONE_CNT)
    `FDC_ASSERT(a_result_from_run, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(w_done))
    `FDC_ASSERT(a_run_holds, i_clk, i_rst_n, (r_busy && !w_load) |=> r_busy)
    `FDC_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !r_busy && !r_out_valid)

endmodule

`default_nettype wire
